// ===== sv/nalg_pkg.sv =====
// ----------------------------------------------------------------------------
// nalg_pkg
// Shared types and constants of the NAL unit parameter-set gate: the queue
// entry passed from the framing front end to the parser, the configuration
// bundle, NAL type codes and gate step codes.
// ----------------------------------------------------------------------------
package nalg_pkg;

  // Default width of the length-prefix byte counter.
  localparam int LENGTH_BITS_DEF = 32;
  // Default depth of the queue between front end and parser.
  localparam int QUEUE_DEPTH_DEF = 4;
  // A length prefix is four bytes, big-endian.
  localparam int PREFIX_BITS     = 32;
  // Look-ahead window: current byte plus marker and header byte.
  localparam int WIN_BYTES       = 5;
  localparam int HIST_BYTES      = 4;

  // Configuration register indexes.
  localparam logic CFG_CODEC_MODE       = 1'b0;
  localparam logic CFG_PARAMS_PRELOADED = 1'b1;

  // Header byte masks and start code terminator.
  localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
  localparam logic [7:0] H265_TYPE_MASK = 8'h7E;
  localparam logic [7:0] SC_ONE         = 8'h01;

  // NAL unit types.
  localparam logic [5:0] H264_SPS     = 6'd7;
  localparam logic [5:0] H264_PPS     = 6'd8;
  localparam logic [5:0] H264_IDR     = 6'd5;
  localparam logic [5:0] H265_VPS     = 6'd32;
  localparam logic [5:0] H265_SPS     = 6'd33;
  localparam logic [5:0] H265_PPS     = 6'd34;
  localparam logic [5:0] H265_IRAP_LO = 6'd16;
  localparam logic [5:0] H265_IRAP_HI = 6'd21;

  // Gate steps.
  localparam logic [2:0] STEP_0        = 3'd0;
  localparam logic [2:0] STEP_1        = 3'd1;
  localparam logic [2:0] STEP_2        = 3'd2;
  localparam logic [2:0] STEP_3        = 3'd3;
  localparam logic [2:0] STEP_4        = 3'd4;
  localparam logic [2:0] H264_OPEN     = 3'd3;
  localparam logic [2:0] H265_OPEN     = 3'd4;
  localparam logic [2:0] H264_WAIT_KEY = 3'd2;
  localparam logic [2:0] H265_WAIT_KEY = 3'd3;

  typedef struct packed {
    logic codec_mode;
    logic params_preloaded;
  } cfg_t;

  // One byte to be parsed, with the packet bytes that follow it.
  typedef struct packed {
    logic [WIN_BYTES-1:0][7:0] win;    // win[0] is the byte itself
    logic [2:0]                avail;  // bytes of win that lie inside the packet
    logic                      eop;    // last byte of the packet
    logic                      sop;    // first byte of the packet
  } entry_t;

endpackage

// ===== sv/nal_unit_parameter_set_gate_top.sv =====
// ----------------------------------------------------------------------------
// nal_unit_parameter_set_gate_top
// Splits video packets into NAL units and gates decoding on parameter sets.
// ----------------------------------------------------------------------------
// Usage: packet bytes enter on the in_ channel (valid/ready), one beat per
// byte, in_last_in_packet on the final byte. Each byte comes back on the out_
// channel with its unit framing, unit type and capture mark; a byte leaves
// once the four bytes after it have arrived, and the packet's last beat
// releases the held bytes, with out_end_of_packet and out_packet_accepted
// on the final result. The user must write the registers on the cfg_ port
// (codec mode, parameter sets preloaded) only while no packet is in flight;
// the block does not enforce this. Throughput is one byte per cycle inside
// a packet while the queue has room. After a packet's last byte, in_ready
// stays low while the front end releases one held byte per cycle, as the
// queue has room. From the beat that completes a byte's window, its result
// passes the queue write, then the parser and output register.
// Reset (synchronous, rst_n low) empties the queue and output register,
// closes the gate and selects H.264 rules. When the receiver stalls, the
// output register holds its beat, the parser stops, the queue fills, and
// in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module nal_unit_parameter_set_gate_top #(
  parameter int LENGTH_BITS = nalg_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = nalg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_in_packet,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_first_of_nal,
  output logic [5:0] out_unit_type,
  output logic       out_keep_for_params,
  output logic       out_end_of_packet,
  output logic       out_packet_accepted,
  output logic       out_decoder_open,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic       cfg_wdata
);

  nalg_pkg::cfg_t   cfg_r;
  logic             push, q_full, q_valid, q_pop;
  nalg_pkg::entry_t push_entry, q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        nalg_pkg::CFG_CODEC_MODE:       cfg_r.codec_mode       <= cfg_wdata;
        nalg_pkg::CFG_PARAMS_PRELOADED: cfg_r.params_preloaded <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  nalg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_in_packet (in_last_in_packet),
    .push              (push),
    .push_entry        (push_entry),
    .q_full            (q_full)
  );

  nalg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  nalg_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_valid             (q_valid),
    .q_entry             (q_entry),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_first_of_nal    (out_first_of_nal),
    .out_unit_type       (out_unit_type),
    .out_keep_for_params (out_keep_for_params),
    .out_end_of_packet   (out_end_of_packet),
    .out_packet_accepted (out_packet_accepted),
    .out_decoder_open    (out_decoder_open)
  );

endmodule

// ===== sv/nalg_front.sv =====
// ----------------------------------------------------------------------------
// nalg_front
// Input front end: holds the last four packet bytes so each byte leaves with
// its four successors, and flushes the held bytes when the packet ends.
// ----------------------------------------------------------------------------
module nalg_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_in_packet,
  output logic            push,
  output nalg_pkg::entry_t push_entry,
  input  logic            q_full
);

  logic [nalg_pkg::HIST_BYTES-1:0][7:0] win_r, win_nxt;
  logic [2:0]                           cnt_r, cnt_nxt;
  logic                                 flush_r, flush_nxt;
  logic                                 sop_r, sop_nxt;
  logic [nalg_pkg::WIN_BYTES-1:0][7:0]  ext;
  logic                                 accept;

  assign in_ready = !flush_r && !q_full;
  assign accept   = in_valid && in_ready;

  // Held bytes with the incoming byte placed right after them.
  always_comb begin
    for (int k = 0; k < nalg_pkg::HIST_BYTES; k++) begin
      if (3'(k) < cnt_r) begin
        ext[k] = win_r[k];
      end else if (3'(k) == cnt_r) begin
        ext[k] = in_data_byte;
      end else begin
        ext[k] = '0;
      end
    end
    ext[nalg_pkg::WIN_BYTES-1] = (cnt_r == 3'(nalg_pkg::HIST_BYTES)) ? in_data_byte : '0;
  end

  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    flush_nxt  = flush_r;
    sop_nxt    = sop_r;
    if (flush_r) begin
      push_entry.win   = {8'h00, win_r};
      push_entry.avail = cnt_r;
      push_entry.eop   = (cnt_r == 3'd1);
      push_entry.sop   = sop_r;
      if (!q_full) begin
        push = 1'b1;
        for (int k = 0; k < nalg_pkg::HIST_BYTES - 1; k++) begin
          win_nxt[k] = win_r[k+1];
        end
        win_nxt[nalg_pkg::HIST_BYTES-1] = '0;
        cnt_nxt   = cnt_r - 3'd1;
        flush_nxt = (cnt_r != 3'd1);
        sop_nxt   = push_entry.eop;
      end
    end else if (accept) begin
      if (in_last_in_packet || cnt_r == 3'(nalg_pkg::HIST_BYTES)) begin
        push             = 1'b1;
        push_entry.win   = ext;
        push_entry.avail = in_last_in_packet ? cnt_r + 3'd1 : 3'(nalg_pkg::WIN_BYTES);
        push_entry.eop   = in_last_in_packet && (cnt_r == 3'd0);
        push_entry.sop   = sop_r;
        sop_nxt          = push_entry.eop;
        for (int k = 0; k < nalg_pkg::HIST_BYTES; k++) begin
          win_nxt[k] = ext[k+1];
        end
        cnt_nxt   = in_last_in_packet ? cnt_r : 3'(nalg_pkg::HIST_BYTES);
        flush_nxt = in_last_in_packet && (cnt_r != 3'd0);
      end else begin
        for (int k = 0; k < nalg_pkg::HIST_BYTES; k++) begin
          win_nxt[k] = ext[k];
        end
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flush_r <= 1'b0;
      sop_r   <= 1'b1;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      sop_r   <= sop_nxt;
    end
    win_r <= win_nxt;
  end

endmodule

// ===== sv/nalg_queue.sv =====
// ----------------------------------------------------------------------------
// nalg_queue
// Small first-in first-out queue of window entries between the front end
// and the parser.
// ----------------------------------------------------------------------------
module nalg_queue #(
  parameter int DEPTH = nalg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  nalg_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output nalg_pkg::entry_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nalg_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== sv/nalg_back.sv =====
// ----------------------------------------------------------------------------
// nalg_back
// Parser back end: frames NAL units by start code or length prefix, reads
// the unit type, advances the parameter-set gate and registers one result
// per byte.
// ----------------------------------------------------------------------------
module nalg_back #(
  parameter int LENGTH_BITS = nalg_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  nalg_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  nalg_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_first_of_nal,
  output logic [5:0]       out_unit_type,
  output logic             out_keep_for_params,
  output logic             out_end_of_packet,
  output logic             out_packet_accepted,
  output logic             out_decoder_open
);

  localparam int CW = nalg_pkg::PREFIX_BITS + 1;
  localparam logic [CW-1:0] LEN_CAP = (CW'(1) << LENGTH_BITS) - CW'(1);

  logic [2:0]             step_r, step_nxt;
  logic                   lf_r, lf_nxt;
  logic [LENGTH_BITS-1:0] bl_r, bl_nxt;
  logic                   hp_r, hp_nxt;
  logic                   keep_r, keep_nxt;
  logic [5:0]             type_r, type_nxt;
  logic                   byp_r, byp_nxt;

  logic                   ov_r;
  logic [7:0]             o_byte_r;
  logic                   o_first_r, o_keep_r, o_eop_r, o_acc_r, o_open_r;
  logic [5:0]             o_type_r;
  logic                   first;
  logic                   is_open;

  assign q_pop = q_valid && (!ov_r || out_ready);

  always_comb begin
    logic [2:0]    lvl;
    logic          sc4, sc3, begin_unit, mark4, hdr_ok;
    logic [7:0]    hb;
    logic [5:0]    t;
    logic [CW-1:0] len_cnt;

    step_nxt = step_r;
    lf_nxt   = lf_r;
    bl_nxt   = bl_r;
    hp_nxt   = hp_r;
    keep_nxt = keep_r;
    type_nxt = type_r;
    byp_nxt  = byp_r;
    first    = 1'b0;
    lvl      = cfg.codec_mode ? nalg_pkg::H265_OPEN : nalg_pkg::H264_OPEN;

    // Packet start: optional jump past parameter sets, then fresh framing.
    if (q_entry.sop) begin
      if (step_nxt == nalg_pkg::STEP_0 && cfg.params_preloaded) begin
        step_nxt = cfg.codec_mode ? nalg_pkg::H265_WAIT_KEY : nalg_pkg::H264_WAIT_KEY;
      end
      byp_nxt  = (step_nxt >= lvl);
      hp_nxt   = 1'b1;
      lf_nxt   = 1'b0;
      bl_nxt   = '0;
      type_nxt = '0;
      keep_nxt = 1'b0;
    end

    sc4 = (q_entry.avail >= 3'd4) && q_entry.win[0] == 8'h00 && q_entry.win[1] == 8'h00 &&
          q_entry.win[2] == 8'h00 && q_entry.win[3] == nalg_pkg::SC_ONE;
    sc3 = (q_entry.avail >= 3'd3) && q_entry.win[0] == 8'h00 && q_entry.win[1] == 8'h00 &&
          q_entry.win[2] == nalg_pkg::SC_ONE;
    len_cnt = {1'b0, q_entry.win[0], q_entry.win[1], q_entry.win[2], q_entry.win[3]}
              + CW'(3);
    begin_unit = 1'b0;
    hdr_ok     = 1'b0;
    mark4      = 1'b1;
    hb         = '0;
    t          = '0;

    if (!byp_nxt) begin
      // A start code opens a new unit only outside a counted unit.
      begin_unit = hp_nxt || (!lf_nxt && bl_nxt == '0 && q_entry.avail >= 3'd4 &&
                              (sc4 || sc3));
      if (begin_unit) begin
        hp_nxt = 1'b0;
        if (sc4 || sc3) begin
          mark4  = sc4;
          lf_nxt = 1'b0;
          bl_nxt = sc4 ? LENGTH_BITS'(3) : LENGTH_BITS'(2);
        end else if (q_entry.avail >= 3'd4) begin
          mark4  = 1'b1;
          lf_nxt = 1'b1;
          bl_nxt = (len_cnt > LEN_CAP) ? LEN_CAP[LENGTH_BITS-1:0] : len_cnt[LENGTH_BITS-1:0];
        end else begin
          // Too few bytes left to frame a unit: rest of packet passes through.
          byp_nxt  = 1'b1;
          type_nxt = '0;
          keep_nxt = 1'b0;
        end
        if (!byp_nxt) begin
          first  = 1'b1;
          hdr_ok = mark4 ? (q_entry.avail == 3'd5) : (q_entry.avail >= 3'd4);
          hb     = mark4 ? q_entry.win[4] : q_entry.win[3];
          if (hdr_ok) begin
            if (cfg.codec_mode) begin
              t = 6'((hb & nalg_pkg::H265_TYPE_MASK) >> 1);
            end else begin
              t = 6'(hb & nalg_pkg::H264_TYPE_MASK);
            end
            type_nxt = t;
            keep_nxt = 1'b0;
            if (!cfg.codec_mode) begin
              if (t == nalg_pkg::H264_SPS && step_nxt == nalg_pkg::STEP_0) begin
                step_nxt = nalg_pkg::STEP_1;
                keep_nxt = 1'b1;
              end else if (t == nalg_pkg::H264_PPS && step_nxt == nalg_pkg::STEP_1) begin
                step_nxt = nalg_pkg::STEP_2;
                keep_nxt = 1'b1;
              end else if (t == nalg_pkg::H264_IDR && step_nxt == nalg_pkg::STEP_2) begin
                step_nxt = nalg_pkg::STEP_3;
              end
            end else begin
              if (t == nalg_pkg::H265_VPS && step_nxt == nalg_pkg::STEP_0) begin
                step_nxt = nalg_pkg::STEP_1;
                keep_nxt = 1'b1;
              end else if (t == nalg_pkg::H265_SPS && step_nxt == nalg_pkg::STEP_1) begin
                step_nxt = nalg_pkg::STEP_2;
                keep_nxt = 1'b1;
              end else if (t == nalg_pkg::H265_PPS && step_nxt == nalg_pkg::STEP_2) begin
                step_nxt = nalg_pkg::STEP_3;
                keep_nxt = 1'b1;
              end else if (t >= nalg_pkg::H265_IRAP_LO && t <= nalg_pkg::H265_IRAP_HI &&
                           step_nxt == nalg_pkg::STEP_3) begin
                step_nxt = nalg_pkg::STEP_4;
              end
            end
          end else begin
            type_nxt = '0;
            keep_nxt = 1'b0;
          end
        end
      end else if (bl_nxt != '0) begin
        bl_nxt = bl_nxt - LENGTH_BITS'(1);
        if (lf_nxt && bl_nxt == '0) begin
          hp_nxt = 1'b1;
        end
      end
    end

    is_open = (step_nxt >= lvl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= nalg_pkg::STEP_0;
      lf_r   <= 1'b0;
      bl_r   <= '0;
      hp_r   <= 1'b0;
      keep_r <= 1'b0;
      type_r <= '0;
      byp_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        step_r <= step_nxt;
        lf_r   <= lf_nxt;
        bl_r   <= bl_nxt;
        hp_r   <= hp_nxt;
        keep_r <= keep_nxt;
        type_r <= type_nxt;
        byp_r  <= byp_nxt;
        ov_r   <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
    if (q_pop) begin
      o_byte_r  <= q_entry.win[0];
      o_first_r <= first;
      o_type_r  <= byp_nxt ? 6'd0 : type_nxt;
      o_keep_r  <= byp_nxt ? 1'b0 : keep_nxt;
      o_eop_r   <= q_entry.eop;
      o_acc_r   <= q_entry.eop && is_open;
      o_open_r  <= is_open;
    end
  end

  assign out_valid           = ov_r;
  assign out_byte            = o_byte_r;
  assign out_first_of_nal    = o_first_r;
  assign out_unit_type       = o_type_r;
  assign out_keep_for_params = o_keep_r;
  assign out_end_of_packet   = o_eop_r;
  assign out_packet_accepted = o_acc_r;
  assign out_decoder_open    = o_open_r;

endmodule
